/* hw/rtl/rar_pkg.sv */
`timescale 1ns / 1ps

package rar_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W = 2 * OPERAND_WIDTH;
  localparam int SUM_W = PROD_W + 1;
  localparam int AW = SUM_W + 1;
  localparam int NUM_OUT_W = 33;
  localparam int DEN_OUT_W = 32;
  localparam int EXT_W = SUM_W + NUM_OUT_W;
  localparam int CNT_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_ZERO_DEN = 2'd1,
    ERR_DIV_ZERO = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_ABS,
    ALU_MUL
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_D,
    ST_ADD,
    ST_PREP,
    ST_GCD_TWO,
    ST_GCD_LOOP,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]                      operation;
    logic signed [OPERAND_WIDTH-1:0] a_numerator;
    logic signed [OPERAND_WIDTH-1:0] a_denominator;
    logic signed [OPERAND_WIDTH-1:0] b_numerator;
    logic signed [OPERAND_WIDTH-1:0] b_denominator;
  } in_item_t;

  typedef struct packed {
    logic signed [NUM_OUT_W-1:0] result_numerator;
    logic signed [DEN_OUT_W-1:0] result_denominator;
    logic [1:0]                  error_code;
  } out_item_t;

  typedef struct packed {
    alu_op_t       op;
    logic [AW-1:0] a;
    logic [AW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [AW-1:0] res;
    logic          borrow;
  } alu_rsp_t;

  function automatic logic [OPERAND_WIDTH-1:0] sm_mag(input logic [OPERAND_WIDTH-1:0] v);
    return v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

/* hw/rtl/rar_alu.sv */
`timescale 1ns / 1ps

module rar_alu (
  input  rar_pkg::alu_req_t alu_req,
  output rar_pkg::alu_rsp_t alu_rsp
);
  import rar_pkg::*;

  logic [AW:0]     diff;
  logic [AW-1:0]   sum;
  logic [PROD_W-1:0] prod;

  assign diff = {1'b0, alu_req.a} - {1'b0, alu_req.b};
  assign sum  = alu_req.a + alu_req.b;
  assign prod = PROD_W'(alu_req.a[OPERAND_WIDTH-1:0]) * PROD_W'(alu_req.b[OPERAND_WIDTH-1:0]);

  always_comb begin
    alu_rsp.borrow = diff[AW];
    case (alu_req.op)
      ALU_ADD: alu_rsp.res = sum;
      ALU_SUB: alu_rsp.res = diff[AW-1:0];
      ALU_ABS: alu_rsp.res = diff[AW] ? (~diff[AW-1:0] + 1'b1) : diff[AW-1:0];
      ALU_MUL: alu_rsp.res = AW'(prod);
      default: alu_rsp.res = sum;
    endcase
  end

endmodule

/* hw/rtl/rational_arith_reduce.sv */
`timescale 1ns / 1ps

// Computes a/b + c/d style sums, differences, products and quotients of two signed
// fractions and reduces a nonzero result by the GCD of its magnitudes; signs stay as the
// cross products give them. One transaction is worked on at a time, and in_stall is
// high until its result has been moved to the output register. All arithmetic runs
// through one shared unit that does one multiply, add or subtract per cycle: two
// products for a multiply or divide and three products and a sum for an add or
// subtract, a binary GCD, and two restoring divisions of 33 steps each. Transactions
// with an input error go from idle straight to the finish state.
module rational_arith_reduce (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rar_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rar_pkg::out_item_t out_data
);
  import rar_pkg::*;

  state_t                   state_r, state_nxt;
  op_t                      op_r, op_nxt;
  err_t                     err_r, err_nxt;
  logic                     an_neg_r, an_neg_nxt, ad_neg_r, ad_neg_nxt;
  logic                     bn_neg_r, bn_neg_nxt, bd_neg_r, bd_neg_nxt;
  logic [OPERAND_WIDTH-1:0] an_m_r, an_m_nxt, ad_m_r, ad_m_nxt;
  logic [OPERAND_WIDTH-1:0] bn_m_r, bn_m_nxt, bd_m_r, bd_m_nxt;
  logic [SUM_W-1:0]         x_mag_r, x_mag_nxt;
  logic                     x_neg_r, x_neg_nxt;
  logic [PROD_W-1:0]        y_mag_r, y_mag_nxt;
  logic                     y_neg_r, y_neg_nxt;
  logic [SUM_W-1:0]         den_mag_r, den_mag_nxt;
  logic                     den_neg_r, den_neg_nxt;
  logic [SUM_W-1:0]         u_r, u_nxt, v_r, v_nxt;
  logic [AW-1:0]            rem_r, rem_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic [AW-1:0]    rem_sh;
  logic [EXT_W-1:0] num_ext, den_ext;

  rar_alu u_alu (
    .alu_req (alu_req),
    .alu_rsp (alu_rsp)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rem_sh  = {rem_r[AW-2:0],
                    (state_r == ST_DIV_NUM) ? x_mag_r[SUM_W-1] : den_mag_r[SUM_W-1]};
  assign num_ext = x_neg_r ? -EXT_W'(x_mag_r) : EXT_W'(x_mag_r);
  assign den_ext = den_neg_r ? -EXT_W'(den_mag_r) : EXT_W'(den_mag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    err_r      <= err_nxt;
    an_neg_r   <= an_neg_nxt;
    ad_neg_r   <= ad_neg_nxt;
    bn_neg_r   <= bn_neg_nxt;
    bd_neg_r   <= bd_neg_nxt;
    an_m_r     <= an_m_nxt;
    ad_m_r     <= ad_m_nxt;
    bn_m_r     <= bn_m_nxt;
    bd_m_r     <= bd_m_nxt;
    x_mag_r    <= x_mag_nxt;
    x_neg_r    <= x_neg_nxt;
    y_mag_r    <= y_mag_nxt;
    y_neg_r    <= y_neg_nxt;
    den_mag_r  <= den_mag_nxt;
    den_neg_r  <= den_neg_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    err_nxt       = err_r;
    an_neg_nxt    = an_neg_r;
    ad_neg_nxt    = ad_neg_r;
    bn_neg_nxt    = bn_neg_r;
    bd_neg_nxt    = bd_neg_r;
    an_m_nxt      = an_m_r;
    ad_m_nxt      = ad_m_r;
    bn_m_nxt      = bn_m_r;
    bd_m_nxt      = bd_m_r;
    x_mag_nxt     = x_mag_r;
    x_neg_nxt     = x_neg_r;
    y_mag_nxt     = y_mag_r;
    y_neg_nxt     = y_neg_r;
    den_mag_nxt   = den_mag_r;
    den_neg_nxt   = den_neg_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    alu_req.op    = ALU_ADD;
    alu_req.a     = '0;
    alu_req.b     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = op_t'(in_data.operation);
          an_neg_nxt = in_data.a_numerator[OPERAND_WIDTH-1];
          ad_neg_nxt = in_data.a_denominator[OPERAND_WIDTH-1];
          bn_neg_nxt = in_data.b_numerator[OPERAND_WIDTH-1];
          bd_neg_nxt = in_data.b_denominator[OPERAND_WIDTH-1];
          an_m_nxt   = sm_mag(in_data.a_numerator);
          ad_m_nxt   = sm_mag(in_data.a_denominator);
          bn_m_nxt   = sm_mag(in_data.b_numerator);
          bd_m_nxt   = sm_mag(in_data.b_denominator);
          if (in_data.a_denominator == '0 || in_data.b_denominator == '0) begin
            err_nxt   = ERR_ZERO_DEN;
            state_nxt = ST_FINISH;
          end else if (op_t'(in_data.operation) == OP_DIV && in_data.b_numerator == '0) begin
            err_nxt   = ERR_DIV_ZERO;
            state_nxt = ST_FINISH;
          end else begin
            err_nxt   = ERR_NONE;
            state_nxt = ST_MUL_X;
          end
        end
      end
      ST_MUL_X: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = AW'(an_m_r);
        alu_req.b  = AW'((op_r == OP_MUL) ? bn_m_r : bd_m_r);
        x_mag_nxt  = alu_rsp.res[SUM_W-1:0];
        x_neg_nxt  = an_neg_r ^ ((op_r == OP_MUL) ? bn_neg_r : bd_neg_r);
        state_nxt  = (op_r == OP_ADD || op_r == OP_SUB) ? ST_MUL_Y : ST_MUL_D;
      end
      ST_MUL_Y: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = AW'(bn_m_r);
        alu_req.b  = AW'(ad_m_r);
        y_mag_nxt  = alu_rsp.res[PROD_W-1:0];
        y_neg_nxt  = bn_neg_r ^ ad_neg_r ^ (op_r == OP_SUB);
        state_nxt  = ST_MUL_D;
      end
      ST_MUL_D: begin
        alu_req.op  = ALU_MUL;
        alu_req.a   = AW'(ad_m_r);
        alu_req.b   = AW'((op_r == OP_DIV) ? bn_m_r : bd_m_r);
        den_mag_nxt = alu_rsp.res[SUM_W-1:0];
        den_neg_nxt = ad_neg_r ^ ((op_r == OP_DIV) ? bn_neg_r : bd_neg_r);
        state_nxt   = (op_r == OP_ADD || op_r == OP_SUB) ? ST_ADD : ST_PREP;
      end
      ST_ADD: begin
        alu_req.op = (x_neg_r == y_neg_r) ? ALU_ADD : ALU_ABS;
        alu_req.a  = AW'(x_mag_r);
        alu_req.b  = AW'(y_mag_r);
        x_mag_nxt  = alu_rsp.res[SUM_W-1:0];
        if (x_neg_r != y_neg_r && alu_rsp.borrow) begin
          x_neg_nxt = y_neg_r;
        end
        state_nxt  = ST_PREP;
      end
      ST_PREP: begin
        if (x_mag_r == '0 || den_mag_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          u_nxt     = x_mag_r;
          v_nxt     = den_mag_r;
          state_nxt = ST_GCD_TWO;
        end
      end
      ST_GCD_TWO: begin
        // Common factors of two are divided out of the results right away.
        if (!u_r[0] && !v_r[0]) begin
          u_nxt       = u_r >> 1;
          v_nxt       = v_r >> 1;
          x_mag_nxt   = x_mag_r >> 1;
          den_mag_nxt = den_mag_r >> 1;
        end else begin
          state_nxt = ST_GCD_LOOP;
        end
      end
      ST_GCD_LOOP: begin
        alu_req.op = ALU_ABS;
        alu_req.a  = AW'(u_r);
        alu_req.b  = AW'(v_r);
        if (u_r == '0 || v_r == '0) begin
          if (u_r == '0) begin
            u_nxt = v_r;
          end
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(SUM_W - 1);
          state_nxt = ST_DIV_NUM;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (alu_rsp.borrow) begin
          v_nxt = alu_rsp.res[SUM_W-1:0];
        end else begin
          u_nxt = alu_rsp.res[SUM_W-1:0];
        end
      end
      ST_DIV_NUM, ST_DIV_DEN: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = rem_sh;
        alu_req.b  = AW'(u_r);
        rem_nxt    = alu_rsp.borrow ? rem_sh : alu_rsp.res;
        if (state_r == ST_DIV_NUM) begin
          x_mag_nxt = {x_mag_r[SUM_W-2:0], !alu_rsp.borrow};
        end else begin
          den_mag_nxt = {den_mag_r[SUM_W-2:0], !alu_rsp.borrow};
        end
        if (cnt_r == '0) begin
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(SUM_W - 1);
          state_nxt = (state_r == ST_DIV_NUM) ? ST_DIV_DEN : ST_FINISH;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.error_code = err_r;
          if (err_r != ERR_NONE) begin
            out_data_nxt.result_numerator   = '0;
            out_data_nxt.result_denominator = '0;
          end else begin
            out_data_nxt.result_numerator   = num_ext[NUM_OUT_W-1:0];
            out_data_nxt.result_denominator = den_ext[DEN_OUT_W-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("accepted transaction did not start work");

  a_error_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error_code != ERR_NONE) |->
      (out_data.result_numerator == '0 && out_data.result_denominator == '0))
    else $error("error result carries a nonzero fraction");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_NUM || state_r == ST_DIV_DEN) |-> (u_r != '0))
    else $error("reduction divides by zero");

  a_gcd_one_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GCD_LOOP) |-> (u_r[0] || v_r[0] || u_r == '0 || v_r == '0))
    else $error("both GCD operands even inside the loop");

  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && (!out_valid || !out_stall)) |=> out_valid)
    else $error("finished result not presented");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import rar_pkg::*;

  localparam int HOLD_CYCLES = 600;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;
  localparam int REPORT_LIMIT = 10;

  typedef enum int {
    RX_NEVER,
    RX_CHOPPY,
    RX_SLOW
  } rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;

  out_item_t  fraction_queue[$];
  int         item_count = 0;
  int         result_count = 0;
  int         mismatch_count = 0;
  int         burst_left = 0;
  int         tx_gap_max = 0;
  rx_mode_t   rx_mode = RX_NEVER;
  int         hold_orders = 0;
  int         hold_served = 0;
  int         hold_left = 0;
  int         rx_run_left = 0;
  int         idle_cycles = 0;

  rational_arith_reduce dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint gcd_mag(longint x, longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic out_item_t reduce_fraction(in_item_t it);
    longint an;
    longint ad;
    longint bn;
    longint bd;
    longint num;
    longint den;
    longint g;
    out_item_t r;
    an = $signed(it.a_numerator);
    ad = $signed(it.a_denominator);
    bn = $signed(it.b_numerator);
    bd = $signed(it.b_denominator);
    r = '0;
    if (ad == 0 || bd == 0) begin
      r.error_code = ERR_ZERO_DEN;
      return r;
    end
    if (it.operation == OP_DIV && bn == 0) begin
      r.error_code = ERR_DIV_ZERO;
      return r;
    end
    case (it.operation)
      OP_ADD: begin
        num = an * bd + bn * ad;
        den = ad * bd;
      end
      OP_SUB: begin
        num = an * bd - bn * ad;
        den = ad * bd;
      end
      OP_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        num = an * bd;
        den = ad * bn;
      end
    endcase
    // A zero numerator leaves the denominator unreduced.
    if (num != 0) begin
      g = gcd_mag((num < 0) ? -num : num, (den < 0) ? -den : den);
      num = num / g;
      den = den / g;
    end
    r.result_numerator = num[NUM_OUT_W-1:0];
    r.result_denominator = den[DEN_OUT_W-1:0];
    r.error_code = ERR_NONE;
    return r;
  endfunction

  function automatic in_item_t make_item(op_t op, int an, int ad, int bn, int bd);
    in_item_t it;
    it.operation = op;
    it.a_numerator = an[OPERAND_WIDTH-1:0];
    it.a_denominator = ad[OPERAND_WIDTH-1:0];
    it.b_numerator = bn[OPERAND_WIDTH-1:0];
    it.b_denominator = bd[OPERAND_WIDTH-1:0];
    return it;
  endfunction

  function automatic logic [OPERAND_WIDTH-1:0] rand_operand(bit allow_zero);
    int v;
    int lo;
    int hi;
    lo = -(1 << (OPERAND_WIDTH - 1));
    hi = (1 << (OPERAND_WIDTH - 1)) - 1;
    do begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 4))
            0: v = lo;
            1: v = hi;
            2: v = -1;
            3: v = 1;
            default: v = 0;
          endcase
        end
        1, 2: v = int'($urandom_range(0, 24)) - 12;
        3: begin
          v = int'($urandom_range(1, 15)) << $urandom_range(0, OPERAND_WIDTH - 5);
          if ($urandom_range(0, 1) == 1) v = -v;
        end
        default: v = $urandom;
      endcase
    end while (!allow_zero && v[OPERAND_WIDTH-1:0] == 0);
    return v[OPERAND_WIDTH-1:0];
  endfunction

  function automatic in_item_t random_fraction();
    in_item_t it;
    it.operation = op_t'($urandom_range(OP_ADD, OP_DIV));
    it.a_numerator = rand_operand(1'b1);
    it.a_denominator = rand_operand(1'b0);
    it.b_numerator = rand_operand(1'b1);
    it.b_denominator = rand_operand(1'b0);
    if ($urandom_range(0, 49) == 0) it.a_denominator = '0;
    if ($urandom_range(0, 49) == 0) it.b_denominator = '0;
    return it;
  endfunction

  task automatic send_fraction(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fraction_queue.push_back(reduce_fraction(it));
    item_count++;
  endtask

  task automatic wait_fractions_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (fraction_queue.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    int lo;
    int hi;
    lo = -(1 << (OPERAND_WIDTH - 1));
    hi = (1 << (OPERAND_WIDTH - 1)) - 1;
    tx_gap_max = 0;
    rx_mode = RX_NEVER;
    send_fraction(make_item(OP_ADD, 1, 2, 1, 3));
    send_fraction(make_item(OP_SUB, 1, 2, 1, 2));
    send_fraction(make_item(OP_MUL, 2, 4, 3, 9));
    send_fraction(make_item(OP_DIV, 3, 4, 3, 8));
    send_fraction(make_item(OP_SUB, 7, 3, -5, 3));
    send_fraction(make_item(OP_ADD, hi, hi, hi, hi));
    send_fraction(make_item(OP_ADD, lo, lo, lo, lo));
    send_fraction(make_item(OP_SUB, lo, 1, hi, 1));
    send_fraction(make_item(OP_MUL, lo, hi, lo, hi));
    send_fraction(make_item(OP_MUL, lo, 1, lo, -1));
    send_fraction(make_item(OP_DIV, lo, 1, -1, 1));
    send_fraction(make_item(OP_DIV, 1, lo, lo, 1));
    send_fraction(make_item(OP_DIV, 4096, -8192, -2048, 1024));
    send_fraction(make_item(OP_ADD, 1, -2, 1, -2));
    send_fraction(make_item(OP_ADD, -1, -1, -1, -1));
    // Zero denominators, including ahead of a division by a zero fraction, then divisions by a zero fraction.
    send_fraction(make_item(OP_ADD, 5, 0, 3, 7));
    send_fraction(make_item(OP_MUL, 5, 3, 3, 0));
    send_fraction(make_item(OP_DIV, 5, 0, 0, 0));
    send_fraction(make_item(OP_DIV, 5, 3, 0, 7));
    send_fraction(make_item(OP_DIV, 0, 3, 0, 7));
    // Zero numerators keep the unreduced denominator.
    send_fraction(make_item(OP_MUL, 0, 6, 5, 4));
    send_fraction(make_item(OP_DIV, 0, 6, 5, 4));
    send_fraction(make_item(OP_ADD, 0, hi, 0, lo));
    send_fraction(make_item(OP_SUB, hi, lo, hi, lo));
    wait_fractions_drained();
  endtask

  task automatic test_random_fractions(int count, rx_mode_t mode, int gap_max);
    rx_mode = mode;
    tx_gap_max = gap_max;
    repeat (count) send_fraction(random_fraction());
  endtask

  task automatic test_output_hold();
    rx_mode = RX_NEVER;
    tx_gap_max = 0;
    hold_orders++;
    repeat (8) send_fraction(random_fraction());
    wait_fractions_drained();
  endtask

  task automatic test_pause_and_resume();
    rx_mode = RX_CHOPPY;
    tx_gap_max = 2;
    repeat (20) send_fraction(random_fraction());
    wait_fractions_drained();
    repeat (20) send_fraction(random_fraction());
    wait_fractions_drained();
  endtask

  // The receiver stalls on its own pattern, with a long hold-off on request.
  always @(posedge clk) begin
    if (hold_orders != hold_served) begin
      hold_served = hold_orders;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_run_left > 0) begin
      rx_run_left--;
    end else begin
      case (rx_mode)
        RX_CHOPPY: begin
          out_stall <= $urandom_range(0, 1);
          rx_run_left = $urandom_range(0, 3);
        end
        RX_SLOW: begin
          if (!out_stall) begin
            out_stall <= 1'b1;
            rx_run_left = $urandom_range(0, 40);
          end else begin
            out_stall <= 1'b0;
            rx_run_left = $urandom_range(0, 6);
          end
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (fraction_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result num=%0d den=%0d err=%0d with nothing pending",
                   out_data.result_numerator, out_data.result_denominator,
                   out_data.error_code);
      end else begin
        want = fraction_queue.pop_front();
        result_count++;
        if (out_data.result_numerator !== want.result_numerator ||
            out_data.result_denominator !== want.result_denominator ||
            out_data.error_code !== want.error_code) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on result %0d: expected %0d/%0d err=%0d, got %0d/%0d err=%0d",
                     result_count, want.result_numerator, want.result_denominator,
                     want.error_code, out_data.result_numerator,
                     out_data.result_denominator, out_data.error_code);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a transaction", idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_output_hold();
    test_random_fractions(400, RX_NEVER, 0);
    test_pause_and_resume();
    test_random_fractions(400, RX_CHOPPY, 3);
    test_random_fractions(400, RX_SLOW, 10);
    test_output_hold();
    test_random_fractions(350, RX_CHOPPY, 0);

    wait_fractions_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fraction_queue.size() != 0)
      $display("%0d results never arrived", fraction_queue.size());
    $display("summary: %0d fractions sent, %0d results checked, %0d mismatches",
             item_count, result_count, mismatch_count);
    $display("summary: all operations, operand extremes, both error kinds, output hold-offs");
    if (mismatch_count == 0 && fraction_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
